@@ sv/mcsp_pkg.sv @@
`default_nettype none

package mcsp_pkg;

	localparam int MAX_STATES = 16;
	localparam int MAX_LENGTH = 64;

	localparam int ST_W    = $clog2(MAX_STATES);
	localparam int SC_W    = ST_W + 1;
	localparam int TIME_W  = 6;
	localparam int CFG_W   = 5;
	localparam int IN_C_W  = 24;
	localparam int COST_W  = 32;
	localparam int WIDE_W  = COST_W + 2;
	localparam int BP_W    = ST_W + 1;
	localparam int BP_DEPTH = MAX_LENGTH * MAX_STATES;
	localparam int BP_AW   = $clog2(BP_DEPTH);

	localparam logic [CFG_W-1:0] STATE_COUNT_RST = CFG_W'(MAX_STATES);

	localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
	localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};
	localparam logic signed [COST_W-1:0] NO_PRED_PENALTY = 32'sd1000000000;

	// back pointer with the top bit set marks "no predecessor"
	localparam logic [BP_W-1:0] BP_NONE = {1'b1, {ST_W{1'b0}}};

	// item kinds
	localparam logic [1:0] KIND_OPEN   = 2'd0;
	localparam logic [1:0] KIND_PRED   = 2'd1;
	localparam logic [1:0] KIND_CLOSE  = 2'd2;
	localparam logic [1:0] KIND_FINISH = 2'd3;

	typedef struct packed {
		logic open_en;
		logic pred_en;
		logic close_en;
		logic srch_init;
		logic srch_step;
		logic bp_rd;
		logic bp_step;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       srch_done;
		logic       at_zero;
	} status_t;

	// saturate a widened sum back to the cost range
	function automatic logic signed [COST_W-1:0] sat_cost(input logic signed [WIDE_W-1:0] s);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(COST_MAX);
		lo = WIDE_W'(COST_MIN);
		if (s > hi)
			return COST_MAX;
		else if (s < lo)
			return COST_MIN;
		else
			return s[COST_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/mcsp_if.sv @@
`default_nettype none

interface mcsp_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [3:0]  state_index;
	logic [5:0]  time_index;
	logic [3:0]  pred_state;
	logic signed [23:0] cost_value;

	modport source (output valid, kind, state_index, time_index, pred_state, cost_value,
		input ready);
	modport sink (input valid, kind, state_index, time_index, pred_state, cost_value,
		output ready);
endinterface

interface mcsp_result_if;
	logic       valid;
	logic       ready;
	logic [5:0] out_time;
	logic [3:0] out_state;
	logic       no_path;
	logic       last;

	modport source (output valid, out_time, out_state, no_path, last, input ready);
	modport sink (input valid, out_time, out_state, no_path, last, output ready);
endinterface

interface mcsp_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ sv/mcsp_ram.sv @@
`default_nettype none

module mcsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ sv/mcsp_ctrl.sv @@
`default_nettype none

module mcsp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	output logic                  result_valid,
	input  wire logic             result_ready,
	input  wire mcsp_pkg::status_t sts,
	output mcsp_pkg::cmd_t        cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_EMIT   = 3'd2;
	localparam logic [2:0] S_READ   = 3'd3;
	localparam logic [2:0] S_STEP   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = (state_q == S_EMIT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					unique case (sts.kind)
						mcsp_pkg::KIND_OPEN:  cmd.open_en  = 1'b1;
						mcsp_pkg::KIND_PRED:  cmd.pred_en  = 1'b1;
						mcsp_pkg::KIND_CLOSE: cmd.close_en = 1'b1;
						mcsp_pkg::KIND_FINISH: begin
							cmd.srch_init = 1'b1;
							state_d       = S_SEARCH;
						end
						default: ;
					endcase
				end
			end
			S_SEARCH: begin
				if (sts.srch_done)
					state_d = S_EMIT;
				else
					cmd.srch_step = 1'b1;
			end
			S_EMIT: begin
				if (result_ready)
					state_d = sts.at_zero ? S_IDLE : S_READ;
			end
			S_READ: begin
				cmd.bp_rd = 1'b1;
				state_d   = S_STEP;
			end
			S_STEP: begin
				cmd.bp_step = 1'b1;
				state_d     = S_EMIT;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

`default_nettype wire

@@ sv/mcsp_dp.sv @@
`default_nettype none

module mcsp_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mcsp_pkg::cmd_t             cmd,
	output mcsp_pkg::status_t               sts,
	input  wire logic [1:0]                 kind,
	input  wire logic [mcsp_pkg::ST_W-1:0]  state_index,
	input  wire logic [mcsp_pkg::TIME_W-1:0] time_index,
	input  wire logic [mcsp_pkg::ST_W-1:0]  pred_state,
	input  wire logic signed [mcsp_pkg::IN_C_W-1:0] cost_value,
	input  wire logic                       cfg_we,
	input  wire logic [mcsp_pkg::CFG_W-1:0] cfg_data,
	output logic [mcsp_pkg::TIME_W-1:0]     out_time,
	output logic [mcsp_pkg::ST_W-1:0]       out_state,
	output logic                            no_path,
	output logic                            last
);

	localparam int ST_W   = mcsp_pkg::ST_W;
	localparam int SC_W   = mcsp_pkg::SC_W;
	localparam int TIME_W = mcsp_pkg::TIME_W;
	localparam int COST_W = mcsp_pkg::COST_W;
	localparam int WIDE_W = mcsp_pkg::WIDE_W;
	localparam int IN_C_W = mcsp_pkg::IN_C_W;
	localparam int BP_W   = mcsp_pkg::BP_W;
	localparam int BP_AW  = mcsp_pkg::BP_AW;

	logic [mcsp_pkg::CFG_W-1:0] state_count_q;
	logic [SC_W-1:0]            sc;

	logic [ST_W-1:0]            open_state_q;
	logic [TIME_W-1:0]          open_time_q;
	logic signed [IN_C_W-1:0]   open_cost_q;
	logic signed [COST_W-1:0]   best_sum_q;
	logic [ST_W-1:0]            best_pred_q;
	logic                       best_none_q;
	logic [TIME_W-1:0]          final_time_q;
	logic signed [COST_W-1:0]   col_q [2][mcsp_pkg::MAX_STATES];

	logic [SC_W-1:0]            srch_idx_q;
	logic signed [COST_W-1:0]   bc_q;
	logic [ST_W-1:0]            tr_state_q;
	logic [TIME_W-1:0]          tr_time_q;
	logic                       tr_broken_q;

	logic                       col_sel;
	logic [ST_W-1:0]            idx_sel;
	logic signed [COST_W-1:0]   col_rd;
	logic signed [COST_W-1:0]   cand;
	logic                       pred_ok;
	logic                       close_ok;
	logic signed [WIDE_W-1:0]   addend;
	logic signed [COST_W-1:0]   close_sum;
	logic [BP_W-1:0]            close_bp;
	logic [BP_AW-1:0]           bp_waddr;
	logic [BP_AW-1:0]           bp_raddr;
	logic [BP_W-1:0]            bp_rdata;

	// clamp the configured count to 1..MAX_STATES
	always_comb begin
		priority if (state_count_q == '0)
			sc = SC_W'(1);
		else if (SC_W'(state_count_q) > SC_W'(mcsp_pkg::MAX_STATES))
			sc = SC_W'(mcsp_pkg::MAX_STATES);
		else
			sc = SC_W'(state_count_q);
	end

	// one shared read port on the cost columns
	assign col_sel = cmd.pred_en ? ~open_time_q[0] : final_time_q[0];
	always_comb begin
		priority if (cmd.pred_en)
			idx_sel = pred_state;
		else if (cmd.srch_init)
			idx_sel = '0;
		else
			idx_sel = srch_idx_q[ST_W-1:0];
	end
	assign col_rd = col_q[col_sel][idx_sel];

	assign cand    = mcsp_pkg::sat_cost(WIDE_W'(col_rd) + WIDE_W'(cost_value));
	assign pred_ok = (open_time_q != '0) && ({1'b0, pred_state} < sc);

	assign close_ok = ({1'b0, open_state_q} < sc) &&
		((TIME_W+1)'(open_time_q) < (TIME_W+1)'(mcsp_pkg::MAX_LENGTH));

	always_comb begin
		priority if (open_time_q == '0)
			addend = '0;
		else if (best_none_q)
			addend = WIDE_W'(mcsp_pkg::NO_PRED_PENALTY);
		else
			addend = WIDE_W'(best_sum_q);
	end
	assign close_sum = mcsp_pkg::sat_cost(WIDE_W'(open_cost_q) + addend);
	assign close_bp  = ((open_time_q == '0) || best_none_q) ? mcsp_pkg::BP_NONE :
		{1'b0, best_pred_q};

	assign bp_waddr = BP_AW'(open_time_q) * BP_AW'(mcsp_pkg::MAX_STATES) + BP_AW'(open_state_q);
	assign bp_raddr = BP_AW'(tr_time_q) * BP_AW'(mcsp_pkg::MAX_STATES) + BP_AW'(tr_state_q);

	mcsp_ram #(
		.WIDTH(BP_W),
		.DEPTH(mcsp_pkg::BP_DEPTH)
	) u_bp_ram (
		.clk   (clk),
		.we    (cmd.close_en && close_ok),
		.waddr (bp_waddr),
		.wdata (close_bp),
		.re    (cmd.bp_rd),
		.raddr (bp_raddr),
		.rdata (bp_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q <= mcsp_pkg::STATE_COUNT_RST;
			open_state_q  <= '0;
			open_time_q   <= '0;
			open_cost_q   <= '0;
			best_sum_q    <= mcsp_pkg::COST_MAX;
			best_pred_q   <= '0;
			best_none_q   <= 1'b1;
			final_time_q  <= '0;
			for (int c = 0; c < 2; c++)
				for (int i = 0; i < mcsp_pkg::MAX_STATES; i++)
					col_q[c][i] <= '0;
		end else begin
			if (cfg_we)
				state_count_q <= cfg_data;
			if (cmd.open_en) begin
				open_state_q <= state_index;
				open_time_q  <= time_index;
				open_cost_q  <= cost_value;
				best_sum_q   <= mcsp_pkg::COST_MAX;
				best_none_q  <= 1'b1;
			end
			// keep the cheapest candidate, earliest wins a tie
			if (cmd.pred_en && pred_ok && (best_none_q || cand < best_sum_q)) begin
				best_sum_q  <= cand;
				best_pred_q <= pred_state;
				best_none_q <= 1'b0;
			end
			if (cmd.close_en && close_ok) begin
				col_q[open_time_q[0]][open_state_q] <= close_sum;
				final_time_q <= open_time_q;
			end
		end
	end

	// search and trace registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srch_idx_q  <= '0;
			bc_q        <= '0;
			tr_state_q  <= '0;
			tr_time_q   <= '0;
			tr_broken_q <= 1'b0;
		end else begin
			if (cmd.srch_init) begin
				srch_idx_q  <= SC_W'(1);
				bc_q        <= col_rd;
				tr_state_q  <= '0;
				tr_time_q   <= final_time_q;
				tr_broken_q <= 1'b0;
			end
			if (cmd.srch_step) begin
				if (col_rd < bc_q) begin
					bc_q       <= col_rd;
					tr_state_q <= srch_idx_q[ST_W-1:0];
				end
				srch_idx_q <= srch_idx_q + SC_W'(1);
			end
			if (cmd.bp_step) begin
				if (!tr_broken_q) begin
					if (bp_rdata[BP_W-1]) begin
						tr_broken_q <= 1'b1;
						tr_state_q  <= '0;
					end else begin
						tr_state_q <= bp_rdata[ST_W-1:0];
					end
				end
				tr_time_q <= tr_time_q - TIME_W'(1);
			end
		end
	end

	assign sts.kind      = kind;
	assign sts.srch_done = (srch_idx_q >= sc);
	assign sts.at_zero   = (tr_time_q == '0);

	assign out_time  = tr_time_q;
	assign out_state = tr_state_q;
	assign no_path   = tr_broken_q;
	assign last      = (tr_time_q == '0);

endmodule

`default_nettype wire

@@ sv/min_cost_state_path_top.sv @@
// Min-sum state lattice path finder with traceback.
// item channel: one word per lattice item. kind selects open node, offer a
//   predecessor, close node or finish. Open, predecessor and close words are
//   taken one per cycle while no finish is in progress and produce no result.
// result channel: a finish word starts a search over the state_count costs of
//   the last closed time step, then a walk down the back pointer memory
//   emitting final_time+1 words, last to first, last flagged on time zero.
//   Each word after the first passes through emit, memory read and pointer
//   step states; the back pointer memory has a registered read port.
// item ready stays low from the finish word until the final result is taken.
// cfg channel: writes state_count; always ready; write only while idle.
// Stall: while result ready is low the current word is held unchanged and the
//   walk does not advance.
// Reset: costs clear to zero, state_count returns to 16, no result pending.
//   The back pointer memory is not cleared; reading an entry never written
//   returns an arbitrary pointer.
`default_nettype none

module min_cost_state_path_top (
	input  wire logic     clk,
	input  wire logic     arst_n,
	mcsp_item_if.sink     item,
	mcsp_result_if.source result,
	mcsp_cfg_if.sink      cfg
);

	mcsp_pkg::cmd_t    cmd;
	mcsp_pkg::status_t sts;

	// configuration is taken at once
	assign cfg.ready = 1'b1;

	mcsp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// datapath: lattice registers, cost columns, search and trace walk
	mcsp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (item.kind),
		.state_index (item.state_index),
		.time_index  (item.time_index),
		.pred_state  (item.pred_state),
		.cost_value  (item.cost_value),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg.data),
		.out_time    (result.out_time),
		.out_state   (result.out_state),
		.no_path     (result.no_path),
		.last        (result.last)
	);

endmodule

`default_nettype wire

@@ tb/lattice_path_checker.sv @@
`default_nettype none

module lattice_path_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	mcsp_item_if      item,
	mcsp_result_if    result,
	mcsp_cfg_if       cfg,
	output int        mismatches,
	output int        words_owed
);
	import mcsp_pkg::*;

	typedef struct packed {
		logic [5:0] step;
		logic [3:0] state;
		logic       broken;
		logic       last;
	} path_word_t;

	path_word_t path_words_due[$];

	logic [CFG_W-1:0]         state_count;
	logic signed [COST_W-1:0] col_cost [2][MAX_STATES];
	logic [BP_W-1:0]          back_ptr [BP_DEPTH];
	logic [3:0]               node_state;
	logic [5:0]               node_time;
	logic signed [COST_W-1:0] node_cost;
	logic signed [COST_W-1:0] cheapest;
	logic [BP_W-1:0]          cheapest_from;
	logic [5:0]               last_closed;
	int                       fault_tally;

	function automatic int states_in_use(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (int'(v) > MAX_STATES)
			return MAX_STATES;
		return int'(v);
	endfunction

	// exact sum, clipped to the cost range
	function automatic logic signed [COST_W-1:0] clip_add(input longint a, input longint b);
		longint s;
		s = a + b;
		if (s > longint'(COST_MAX))
			return COST_MAX;
		if (s < longint'(COST_MIN))
			return COST_MIN;
		return s[COST_W-1:0];
	endfunction

	// cheapest final state, then follow the back pointers down to time zero
	function automatic void queue_path(input int n);
		int                       pick;
		logic signed [COST_W-1:0] low;
		logic                     broken;
		logic [BP_W-1:0]          bp;
		path_word_t               w;
		pick = 0;
		low = col_cost[last_closed[0]][0];
		for (int i = 1; i < n; i++) begin
			if (col_cost[last_closed[0]][i] < low) begin
				low = col_cost[last_closed[0]][i];
				pick = i;
			end
		end
		broken = 1'b0;
		for (int t = int'(last_closed); t >= 0; t--) begin
			w.step = 6'(t);
			w.state = broken ? 4'd0 : 4'(pick);
			w.broken = broken;
			w.last = (t == 0);
			path_words_due.push_back(w);
			if (t > 0 && !broken) begin
				bp = back_ptr[t * MAX_STATES + pick];
				if (bp[BP_W-1]) begin
					broken = 1'b1;
					pick = 0;
				end else begin
					pick = int'(bp[ST_W-1:0]);
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int                       n;
		logic signed [COST_W-1:0] cand;
		logic signed [COST_W-1:0] sum;
		logic [BP_W-1:0]          bp;
		path_word_t               w;
		if (!arst_n) begin
			state_count = STATE_COUNT_RST;
			for (int c = 0; c < 2; c++)
				for (int s = 0; s < MAX_STATES; s++)
					col_cost[c][s] = '0;
			for (int i = 0; i < BP_DEPTH; i++)
				back_ptr[i] = '0;
			node_state = '0;
			node_time = '0;
			node_cost = '0;
			cheapest = COST_MAX;
			cheapest_from = BP_NONE;
			last_closed = '0;
			path_words_due.delete();
			fault_tally = 0;
		end else begin
			// compare first: a new finish cannot share a cycle with its own words
			if (result.valid && result.ready) begin
				if (path_words_due.size() == 0) begin
					$error("unexpected path word: out_time %0d out_state %0d no_path %0b last %0b",
						result.out_time, result.out_state, result.no_path, result.last);
					fault_tally++;
				end else begin
					w = path_words_due.pop_front();
					if (result.out_time !== w.step) begin
						$error("out_time: expected %0d, got %0d", w.step, result.out_time);
						fault_tally++;
					end
					if (result.out_state !== w.state) begin
						$error("out_state: expected %0d, got %0d", w.state, result.out_state);
						fault_tally++;
					end
					if (result.no_path !== w.broken) begin
						$error("no_path: expected %0b, got %0b", w.broken, result.no_path);
						fault_tally++;
					end
					if (result.last !== w.last) begin
						$error("last: expected %0b, got %0b", w.last, result.last);
						fault_tally++;
					end
				end
			end

			if (cfg.valid && cfg.ready)
				state_count = cfg.data;

			if (item.valid && item.ready) begin
				n = states_in_use(state_count);
				case (item.kind)
					KIND_OPEN: begin
						node_state = item.state_index;
						node_time = item.time_index;
						node_cost = {{(COST_W-IN_C_W){item.cost_value[IN_C_W-1]}}, item.cost_value};
						cheapest = COST_MAX;
						cheapest_from = BP_NONE;
					end
					KIND_PRED: begin
						if (node_time != 0 && int'(item.pred_state) < n) begin
							cand = clip_add(col_cost[~node_time[0]][item.pred_state],
								item.cost_value);
							if (cheapest_from == BP_NONE || cand < cheapest) begin
								cheapest = cand;
								cheapest_from = {1'b0, item.pred_state};
							end
						end
					end
					KIND_CLOSE: begin
						if (int'(node_state) < n && int'(node_time) < MAX_LENGTH) begin
							if (node_time == 0) begin
								sum = node_cost;
								bp = BP_NONE;
							end else if (cheapest_from == BP_NONE) begin
								sum = clip_add(node_cost, NO_PRED_PENALTY);
								bp = BP_NONE;
							end else begin
								sum = clip_add(node_cost, cheapest);
								bp = cheapest_from;
							end
							col_cost[node_time[0]][node_state] = sum;
							back_ptr[int'(node_time) * MAX_STATES + int'(node_state)] = bp;
							last_closed = node_time;
						end
					end
					KIND_FINISH: queue_path(n);
				endcase
			end
		end
		mismatches <= fault_tally;
		words_owed <= path_words_due.size();
	end

endmodule

`default_nettype wire

@@ tb/tb_min_cost_state_path_top.sv @@
`default_nettype none

module tb_min_cost_state_path_top;
	import mcsp_pkg::*;

	// consecutive cycles with no word moving on any channel before giving up
	localparam int IDLE_LIMIT = 2000;
	localparam int WORD_TARGET = 430;
	localparam logic signed [IN_C_W-1:0] IN_COST_MIN = {1'b1, {(IN_C_W-1){1'b0}}};
	localparam logic signed [IN_C_W-1:0] IN_COST_MAX = {1'b0, {(IN_C_W-1){1'b1}}};

	logic clk;
	logic arst_n;
	int   slips;
	int   owed;
	int   words_sent = 0;
	int   burst_left = 0;
	int   hold_left = 0;

	mcsp_item_if   item_bus ();
	mcsp_result_if result_bus ();
	mcsp_cfg_if    cfg_bus ();

	min_cost_state_path_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// the checker sees every channel, mirrors the lattice and owns the comparison
	lattice_path_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_bus),
		.result     (result_bus),
		.cfg        (cfg_bus),
		.mismatches (slips),
		.words_owed (owed)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Result side back-pressure: pick a level and hold it for a while. Long
	// ready stretches give runs with no stalling; short lows land stalls on
	// every phase of the walk.
	always @(posedge clk) begin
		if (hold_left == 0) begin
			case ($urandom_range(0, 5))
				0: begin
					result_bus.ready <= 1'b0;
					hold_left <= $urandom_range(1, 20);
				end
				1: begin
					result_bus.ready <= 1'b0;
					hold_left <= $urandom_range(0, 3);
				end
				2: begin
					result_bus.ready <= 1'b1;
					hold_left <= $urandom_range(40, 80);
				end
				default: begin
					result_bus.ready <= 1'b1;
					hold_left <= $urandom_range(0, 6);
				end
			endcase
		end else begin
			hold_left <= hold_left - 1;
		end
	end

	// Spread of node and transition costs: both ends of the field, a narrow
	// band around zero so that ties turn up, and anything at all.
	function automatic logic signed [IN_C_W-1:0] pick_cost();
		case ($urandom_range(0, 9))
			0: return IN_COST_MIN;
			1: return IN_COST_MAX;
			2, 3: return IN_C_W'($urandom_range(0, 6)) - IN_C_W'(3);
			default: return IN_C_W'($urandom);
		endcase
	endfunction

	// Offer one word on the item channel and hold it until taken. Words go out
	// in bursts; between bursts valid mostly drops for a random gap. Valid is never
	// lowered after a handshake here, so back-to-back words keep it high.
	task automatic put_word(input logic [1:0] k, input logic [3:0] st, input logic [5:0] tm,
		input logic [3:0] pr, input logic signed [IN_C_W-1:0] c, input bit counted);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				item_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_bus.valid <= 1'b1;
		item_bus.kind <= k;
		item_bus.state_index <= st;
		item_bus.time_index <= tm;
		item_bus.pred_state <= pr;
		item_bus.cost_value <= c;
		do @(posedge clk); while (!item_bus.ready);
		if (counted)
			words_sent++;
	endtask

	// unused fields of each kind carry random bits
	task automatic open_node(input int st, input int tm, input logic signed [IN_C_W-1:0] c,
		input bit counted);
		put_word(KIND_OPEN, 4'(st), 6'(tm), 4'($urandom), c, counted);
	endtask

	task automatic offer_pred(input int pr, input logic signed [IN_C_W-1:0] c,
		input bit counted);
		put_word(KIND_PRED, 4'($urandom), 6'($urandom), 4'(pr), c, counted);
	endtask

	task automatic close_node(input bit counted);
		put_word(KIND_CLOSE, 4'($urandom), 6'($urandom), 4'($urandom), IN_C_W'($urandom),
			counted);
	endtask

	task automatic finish_path();
		put_word(KIND_FINISH, 4'($urandom), 6'($urandom), 4'($urandom), IN_C_W'($urandom), 1'b1);
	endtask

	// Drop valid, wait for every path word owed to come back, then give the
	// block a few more cycles to drain any lattice update still in flight.
	// The first edge lets the checker register a finish taken on this edge.
	task automatic settle();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_states(input logic [CFG_W-1:0] v);
		settle();
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= v;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
	endtask

	// Words that leave every back pointer untouched: with spare states, a node
	// opened above state_count and closed again (the close is dropped);
	// otherwise a lone predecessor offer that the next open wipes out.
	task automatic stray_words(input int n);
		if (n < MAX_STATES) begin
			open_node($urandom_range(n, MAX_STATES - 1), $urandom_range(0, MAX_LENGTH - 1),
				pick_cost(), 1'b0);
			if ($urandom_range(0, 1) == 0)
				offer_pred($urandom_range(0, MAX_STATES - 1), pick_cost(), 1'b0);
			close_node(1'b0);
		end else begin
			offer_pred($urandom_range(0, MAX_STATES - 1), pick_cost(), 1'b0);
		end
	endtask

	// Build a full lattice of n states over times 0..top_t, column by column,
	// states in random order, then trace it back. Every node of every column
	// is closed before a finish, so the walk only ever reads pointers written
	// by this lattice. Now and then a column gets only late offers, which puts
	// the penalty on its remaining states and breaks any path through them.
	task automatic grow_lattice(input int n, input int top_t);
		int order [MAX_STATES];
		int j;
		int tmp;
		int preds;
		int pr;
		bit bare_col;
		for (int t = 0; t <= top_t; t++) begin
			bare_col = (t > 0) && ($urandom_range(0, 9) == 0);
			for (int i = 0; i < n; i++)
				order[i] = i;
			for (int i = n - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 7) == 0)
					stray_words(n);
				open_node(order[i], t, pick_cost(), 1'b1);
				preds = bare_col ? 0 : $urandom_range(0, (n < 3) ? n : 3);
				for (int k = 0; k < preds; k++) begin
					// mostly legal states, sometimes any state, even one above state_count
					pr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_STATES - 1)
						: $urandom_range(0, n - 1);
					offer_pred(pr, pick_cost(), (t > 0) && (pr < n));
				end
				close_node(1'b1);
				// late offer and a second close of the same node
				if ($urandom_range(0, 11) == 0) begin
					offer_pred($urandom_range(0, n - 1), pick_cost(), t > 0);
					close_node(1'b1);
				end
			end
			// a complete column is a legal place to trace back early
			if (t < top_t && $urandom_range(0, 9) == 0)
				finish_path();
		end
		finish_path();
	endtask

	// Give up when nothing has moved on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("min_cost_state_path_top verification failed");
		$finish;
	end

	initial begin : stimulus
		int run;
		int n;
		int top_t;
		logic [CFG_W-1:0] setting;

		arst_n = 1'b0;
		item_bus.valid <= 1'b0;
		item_bus.kind <= KIND_OPEN;
		item_bus.state_index <= '0;
		item_bus.time_index <= '0;
		item_bus.pred_state <= '0;
		item_bus.cost_value <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset: nothing closed, all costs zero, so a single
		// word for time zero, state zero.
		finish_path();

		// Two states. Time zero: state 0 dearest with an offer that must be
		// ignored, state 1 cheapest.
		set_states(CFG_W'(2));
		open_node(0, 0, IN_COST_MAX, 1'b1);
		offer_pred(0, IN_COST_MIN, 1'b0);
		close_node(1'b1);
		open_node(1, 0, IN_COST_MIN, 1'b1);
		close_node(1'b1);
		// Time one: state 0 picks state 1; the offer from state 15 lies above
		// state_count and is dropped.
		open_node(0, 1, '0, 1'b1);
		offer_pred(1, '0, 1'b1);
		offer_pred(0, IN_COST_MAX, 1'b1);
		offer_pred(15, IN_COST_MIN, 1'b0);
		close_node(1'b1);
		// state 1 gets no offer at all and carries the penalty
		open_node(1, 1, IN_C_W'(5), 1'b1);
		close_node(1'b1);
		// node above state_count at the top time step: close dropped, last
		// closed time stays at one
		open_node(15, MAX_LENGTH - 1, -IN_C_W'(1), 1'b1);
		close_node(1'b0);
		finish_path();
		// a column with no predecessors anywhere: the path breaks at once
		open_node(0, 2, '0, 1'b1);
		close_node(1'b1);
		open_node(1, 2, '0, 1'b1);
		close_node(1'b1);
		finish_path();

		// Random lattices under changing state counts. Run 1 uses every
		// state with a register value above the clamp; run 3 is the deepest
		// lattice, one state wide, with zero written (treated as one).
		run = 0;
		while (words_sent < WORD_TARGET) begin
			case (run)
				1: begin
					n = MAX_STATES;
					top_t = 1;
					setting = '1;
				end
				3: begin
					n = 1;
					top_t = MAX_LENGTH - 1;
					setting = '0;
				end
				default: begin
					n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
					top_t = $urandom_range(0, 24 / n);
					setting = (n == 1) ? CFG_W'($urandom_range(0, 1)) : CFG_W'(n);
				end
			endcase
			set_states(setting);
			grow_lattice(n, top_t);
			run++;
		end

		settle();
		repeat (24) @(posedge clk);
		if (slips == 0 && owed == 0)
			$display("min_cost_state_path_top verification clean");
		else
			$display("min_cost_state_path_top verification failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/mcsp_pkg.sv
sv/mcsp_if.sv
sv/mcsp_ram.sv
sv/mcsp_ctrl.sv
sv/mcsp_dp.sv
sv/min_cost_state_path_top.sv
tb/lattice_path_checker.sv
tb/tb_min_cost_state_path_top.sv
